// ===== sv/bbo_pkg.sv =====
`timescale 1ns / 1ps
// shared types, sizes and codes for the bypass-bin override table
package bbo_pkg;

  // table geometry
  localparam int BLOCK_CATEGORIES  = 5;
  localparam int SUBBLK_COUNT      = 16;
  localparam int COEFF_POSITIONS   = 16;
  localparam int PARTITIONS        = 16;
  localparam int VECTOR_COMPONENTS = 2;

  localparam int COEFF_DEPTH = BLOCK_CATEGORIES * SUBBLK_COUNT * COEFF_POSITIONS;
  localparam int MVD_DEPTH   = PARTITIONS * VECTOR_COMPONENTS;
  localparam int TOTAL_DEPTH = 2 * COEFF_DEPTH + 2 * MVD_DEPTH;
  localparam int ADDR_W      = $clog2(TOTAL_DEPTH);

  // region bases inside the shared slot memory
  localparam int COEFF_SIGN_BASE = 0;
  localparam int COEFF_LSB_BASE  = COEFF_DEPTH;
  localparam int MVD_SIGN_BASE   = 2 * COEFF_DEPTH;
  localparam int MVD_LSB_BASE    = 2 * COEFF_DEPTH + MVD_DEPTH;

  // slot word: generation tag over the stored override code
  localparam int EPOCH_W = 8;
  localparam int VAL_W   = 2;
  localparam int SLOT_W  = EPOCH_W + VAL_W;

  localparam logic [VAL_W-1:0] VAL_EMPTY = 2'd0;
  localparam logic [VAL_W-1:0] VAL_ONE   = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_APPLY = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  localparam logic [2:0] DOM_COEFF_SIGN = 3'd0;
  localparam logic [2:0] DOM_COEFF_LSB  = 3'd1;
  localparam logic [2:0] DOM_MVD_SIGN   = 3'd2;
  localparam logic [2:0] DOM_MVD_LSB    = 3'd3;

  typedef struct packed {
    logic       original_bin;
    logic [1:0] override_value;
    logic [7:0] vector_component;
    logic [7:0] partition_index;
    logic [7:0] coefficient_index;
    logic [7:0] sub_block_index;
    logic [7:0] block_category;
    logic [2:0] domain;
    opcode_t    opcode;
  } item_t;

  typedef struct packed {
    logic slot_in_range;
    logic was_overridden;
    logic result_bin;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_wr;
    logic load_out;
    logic drop_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic out_valid;
    logic wrap_clear;
  } dp_status_t;

endpackage

// ===== sv/bbo_ctrl.sv =====
`timescale 1ns / 1ps
// controller: clearing sweep, item acceptance and result hand-off
module bbo_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   m_tready,
  input  bbo_pkg::dp_status_t    status,
  output bbo_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RESOLVE
  } state_t;

  state_t state;
  logic   wrap_pending;
  logic   out_free;

  // handshake and command decode
  always_comb begin
    out_free = !status.out_valid || m_tready;
    unique case (state)
      ST_SWEEP:   s_tready = 1'b0;
      ST_IDLE:    s_tready = 1'b1;
      ST_RESOLVE: s_tready = out_free && !wrap_pending;
      default:    s_tready = 1'b0;
    endcase
    cmd.accept   = s_tvalid && s_tready;
    cmd.sweep_wr = (state == ST_SWEEP);
    cmd.load_out = (state == ST_RESOLVE) && out_free;
    cmd.drop_out = status.out_valid && m_tready;
  end

  // state and registered flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      wrap_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          if (status.sweep_done) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd.accept) begin
            state        <= ST_RESOLVE;
            wrap_pending <= status.wrap_clear;
          end
        end
        ST_RESOLVE: begin
          if (out_free) begin
            if (cmd.accept) begin
              wrap_pending <= status.wrap_clear;
            end else if (wrap_pending) begin
              state        <= ST_SWEEP;
              wrap_pending <= 1'b0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_SWEEP;
      endcase
    end
  end

endmodule

// ===== sv/bbo_datapath.sv =====
`timescale 1ns / 1ps
// datapath: slot addressing, tagged slot memory, generation counter, result register
module bbo_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  bbo_pkg::item_t        item,
  input  bbo_pkg::ctrl_cmd_t    cmd,
  output bbo_pkg::dp_status_t   status,
  output bbo_pkg::result_t      result,
  output logic                  result_valid
);

  logic [bbo_pkg::SLOT_W-1:0]  slot_mem [bbo_pkg::TOTAL_DEPTH];
  logic [bbo_pkg::SLOT_W-1:0]  rd_slot;
  logic [bbo_pkg::ADDR_W-1:0]  coef_offset;
  logic [bbo_pkg::ADDR_W-1:0]  mvd_idx;
  logic [bbo_pkg::ADDR_W-1:0]  slot_addr;
  logic [bbo_pkg::ADDR_W-1:0]  sweep_addr;
  logic [bbo_pkg::EPOCH_W-1:0] epoch;
  logic                        coeff_ok;
  logic                        mvd_ok;
  logic                        slot_ok;
  logic                        set_wr;
  logic                        sweep_last;
  logic [bbo_pkg::VAL_W-1:0]   new_val;
  bbo_pkg::opcode_t            op_q;
  logic                        ok_q;
  logic                        orig_q;
  logic [bbo_pkg::EPOCH_W-1:0] rd_tag;
  logic [bbo_pkg::VAL_W-1:0]   rd_val;
  logic                        hit;
  bbo_pkg::result_t            result_next;

  // index range checks and flattened slot address
  always_comb begin
    coeff_ok = (item.block_category < 8'(bbo_pkg::BLOCK_CATEGORIES))
            && (item.sub_block_index < 8'(bbo_pkg::SUBBLK_COUNT))
            && (item.coefficient_index < 8'(bbo_pkg::COEFF_POSITIONS));
    mvd_ok   = (item.partition_index < 8'(bbo_pkg::PARTITIONS))
            && (item.vector_component < 8'(bbo_pkg::VECTOR_COMPONENTS));
    coef_offset = (bbo_pkg::ADDR_W'(item.block_category)
                * bbo_pkg::ADDR_W'(bbo_pkg::SUBBLK_COUNT)
                + bbo_pkg::ADDR_W'(item.sub_block_index))
                * bbo_pkg::ADDR_W'(bbo_pkg::COEFF_POSITIONS)
                + bbo_pkg::ADDR_W'(item.coefficient_index);
    mvd_idx   = bbo_pkg::ADDR_W'(item.partition_index)
              * bbo_pkg::ADDR_W'(bbo_pkg::VECTOR_COMPONENTS)
              + bbo_pkg::ADDR_W'(item.vector_component);
    unique case (item.domain)
      bbo_pkg::DOM_COEFF_SIGN: begin
        slot_ok   = coeff_ok;
        slot_addr = bbo_pkg::ADDR_W'(bbo_pkg::COEFF_SIGN_BASE) + coef_offset;
      end
      bbo_pkg::DOM_COEFF_LSB: begin
        slot_ok   = coeff_ok;
        slot_addr = bbo_pkg::ADDR_W'(bbo_pkg::COEFF_LSB_BASE) + coef_offset;
      end
      bbo_pkg::DOM_MVD_SIGN: begin
        slot_ok   = mvd_ok;
        slot_addr = bbo_pkg::ADDR_W'(bbo_pkg::MVD_SIGN_BASE) + mvd_idx;
      end
      bbo_pkg::DOM_MVD_LSB: begin
        slot_ok   = mvd_ok;
        slot_addr = bbo_pkg::ADDR_W'(bbo_pkg::MVD_LSB_BASE) + mvd_idx;
      end
      default: begin
        slot_ok   = 1'b0;
        slot_addr = '0;
      end
    endcase
  end

  // stored code is the forced bin plus one
  assign new_val    = item.override_value + 2'd1;
  assign set_wr     = cmd.accept && (item.opcode == bbo_pkg::OP_SET) && slot_ok
                   && !item.override_value[1];
  assign sweep_last = (sweep_addr == bbo_pkg::ADDR_W'(bbo_pkg::TOTAL_DEPTH - 1));

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      slot_mem[sweep_addr] <= '0;
    end else if (set_wr) begin
      slot_mem[slot_addr] <= {epoch, new_val};
    end
    if (cmd.accept) begin
      rd_slot <= slot_mem[slot_addr];
    end
  end

  // sweep pointer and generation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      epoch      <= '0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (cmd.accept && (item.opcode == bbo_pkg::OP_CLEAR)) begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  // item fields held for the resolve cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= item.opcode;
      ok_q   <= slot_ok;
      orig_q <= item.original_bin;
    end
  end

  // resolve: slot is live only when its tag matches the current generation
  always_comb begin
    rd_tag = rd_slot[bbo_pkg::SLOT_W-1:bbo_pkg::VAL_W];
    rd_val = rd_slot[bbo_pkg::VAL_W-1:0];
    hit    = (op_q == bbo_pkg::OP_APPLY) && ok_q && (rd_tag == epoch)
          && (rd_val != bbo_pkg::VAL_EMPTY);
    result_next.slot_in_range  = ok_q;
    result_next.was_overridden = hit;
    if (op_q == bbo_pkg::OP_APPLY) begin
      result_next.result_bin = hit ? (rd_val == bbo_pkg::VAL_ONE) : orig_q;
    end else begin
      result_next.result_bin = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (cmd.drop_out) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result <= result_next;
    end
  end

  // status back to the controller
  always_comb begin
    status.sweep_done = sweep_last;
    status.out_valid  = result_valid;
    status.wrap_clear = (item.opcode == bbo_pkg::OP_CLEAR) && (epoch == '1);
  end

endmodule

// ===== sv/bypass_bin_override_table.sv =====
`timescale 1ns / 1ps
// top level of the bypass-bin override table
//
// One result item is returned for every input item, in order. An item reads the slot memory
// (single port, registered read) and is then resolved into the output register, where its
// result shows on m_tvalid; while the output is taken and no generation wrap is pending, a new
// item is accepted every cycle. Clear is constant time: it bumps an 8-bit generation tag,
// and slots with a stale tag read as empty. After reset, and after every 256th clear once
// that clear's result has moved into the output register, a clearing pass writes all 2624
// slots, one per cycle, during which s_tready is low.
module bypass_bin_override_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, domain, block_category, sub_block_index, coefficient_index,
  // partition_index, vector_component, override_value, original_bin
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_bin, was_overridden, slot_in_range, zero padding
  output logic [7:0]  m_tdata
);

  bbo_pkg::item_t      item;
  bbo_pkg::ctrl_cmd_t  cmd;
  bbo_pkg::dp_status_t status;
  bbo_pkg::result_t    result;

  // unpack input item
  assign item = bbo_pkg::item_t'(s_tdata);

  bbo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bbo_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (m_tvalid)
  );

  // pack result item
  assign m_tdata = {5'd0, result};

endmodule

// ===== sv/bbo_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the bypass-bin override table, bound to the top level
module bbo_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // reset leaves the block clearing with no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("block not clearing after reset");

  // an override is only found in an addressable slot
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[2])
    else $error("override reported for out-of-range slot");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:3] == 5'd0))
    else $error("nonzero padding in result item");

endmodule

bind bypass_bin_override_table bbo_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the bypass-bin override table
module tb;

  // stored slot codes as the predictor keeps them
  localparam logic [1:0] KEEP_BIN   = 2'd0;
  localparam logic [1:0] FORCE_ZERO = 2'd1;
  localparam logic [1:0] FORCE_ONE  = 2'd2;

  // domain codes past the valid ones
  localparam logic [2:0] DOM_BAD_LO = 3'd4;
  localparam logic [2:0] DOM_BAD_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 150;

  // predicts the table and checks returned bins in order
  class bin_override_scoreboard;
    logic [1:0]       slots [4][bbo_pkg::COEFF_DEPTH];
    bbo_pkg::result_t expected_q [$];
    int               errors;

    function new();
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      foreach (slots[d, i]) slots[d][i] = KEEP_BIN;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // update the table for one accepted item and queue its result
    function void note_item(bbo_pkg::item_t it);
      bbo_pkg::result_t exp;
      logic             ok;
      int               idx;
      logic [1:0]       d;
      exp = '0;
      ok  = 1'b0;
      idx = 0;
      d   = it.domain[1:0];
      if (it.domain == bbo_pkg::DOM_COEFF_SIGN || it.domain == bbo_pkg::DOM_COEFF_LSB) begin
        ok = (it.block_category < bbo_pkg::BLOCK_CATEGORIES) &&
             (it.sub_block_index < bbo_pkg::SUBBLK_COUNT) &&
             (it.coefficient_index < bbo_pkg::COEFF_POSITIONS);
        idx = (int'(it.block_category) * bbo_pkg::SUBBLK_COUNT + int'(it.sub_block_index)) *
              bbo_pkg::COEFF_POSITIONS + int'(it.coefficient_index);
      end else if (it.domain == bbo_pkg::DOM_MVD_SIGN ||
                   it.domain == bbo_pkg::DOM_MVD_LSB) begin
        ok = (it.partition_index < bbo_pkg::PARTITIONS) &&
             (it.vector_component < bbo_pkg::VECTOR_COMPONENTS);
        idx = int'(it.partition_index) * bbo_pkg::VECTOR_COMPONENTS +
              int'(it.vector_component);
      end
      exp.slot_in_range = ok;
      case (it.opcode)
        bbo_pkg::OP_CLEAR: clear_table();
        bbo_pkg::OP_SET: begin
          if (ok && it.override_value <= 2'd1)
            slots[d][idx] = it.override_value[0] ? FORCE_ONE : FORCE_ZERO;
        end
        bbo_pkg::OP_APPLY: begin
          exp.result_bin = it.original_bin;
          if (ok && slots[d][idx] != KEEP_BIN) begin
            exp.result_bin     = (slots[d][idx] == FORCE_ONE);
            exp.was_overridden = 1'b1;
          end
        end
        default: ;
      endcase
      expected_q.push_back(exp);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // compare one result item with the oldest expectation
    task check_result(bbo_pkg::result_t got);
      bbo_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result item with nothing outstanding");
      end else begin
        exp = expected_q.pop_front();
        if (got.result_bin !== exp.result_bin)
          report_mismatch($sformatf("result_bin got %b exp %b", got.result_bin,
                                    exp.result_bin));
        if (got.was_overridden !== exp.was_overridden)
          report_mismatch($sformatf("was_overridden got %b exp %b", got.was_overridden,
                                    exp.was_overridden));
        if (got.slot_in_range !== exp.slot_in_range)
          report_mismatch($sformatf("slot_in_range got %b exp %b", got.slot_in_range,
                                    exp.slot_in_range));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  bin_override_scoreboard sb = new();
  int   results_seen = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  logic [7:0] pool_cat [8];
  logic [7:0] pool_sub [8];
  logic [7:0] pool_pos [8];
  logic [7:0] pool_part [8];
  logic [7:0] pool_comp [8];

  bypass_bin_override_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bbo_pkg::item_t make_item(bbo_pkg::opcode_t op, logic [2:0] dom,
                                               logic [7:0] cat, logic [7:0] sub,
                                               logic [7:0] pos, logic [7:0] part,
                                               logic [7:0] comp, logic [1:0] ovr,
                                               logic orig);
    bbo_pkg::item_t it;
    it.opcode            = op;
    it.domain            = dom;
    it.block_category    = cat;
    it.sub_block_index   = sub;
    it.coefficient_index = pos;
    it.partition_index   = part;
    it.vector_component  = comp;
    it.override_value    = ovr;
    it.original_bin      = orig;
    return it;
  endfunction

  // mostly pooled valid slots so that applies find earlier sets, some raw noise
  function automatic bbo_pkg::item_t random_item(int clear_pct);
    bbo_pkg::item_t it;
    logic [63:0]    raw;
    int             k;
    int             p;
    raw = {$urandom, $urandom};
    it  = bbo_pkg::item_t'(raw[47:0]);
    k   = $urandom_range(0, 99);
    if (k < clear_pct) begin
      it.opcode = bbo_pkg::OP_CLEAR;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 45) it.opcode = bbo_pkg::OP_SET;
      else if (k < 95) it.opcode = bbo_pkg::OP_APPLY;
      else it.opcode = bbo_pkg::OP_NOP;
    end
    if ($urandom_range(0, 9) != 0) it.domain = 3'($urandom_range(0, 3));
    if ($urandom_range(0, 6) != 0) begin
      p = $urandom_range(0, 7);
      it.block_category    = pool_cat[p];
      it.sub_block_index   = pool_sub[p];
      it.coefficient_index = pool_pos[p];
      it.partition_index   = pool_part[p];
      it.vector_component  = pool_comp[p];
    end
    if ($urandom_range(0, 7) != 0) it.override_value = 2'($urandom_range(0, 1));
    return it;
  endfunction

  // offer one item in bursts with random gaps, return once it is taken
  task send_item(bbo_pkg::item_t it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // handshake monitor: inputs feed the predictor, outputs are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(bbo_pkg::item_t'(s_tdata));
      if (m_tvalid && m_tready) begin
        sb.check_result(bbo_pkg::result_t'(m_tdata[2:0]));
        results_seen++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bypass_bin_override_table verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls: ready always, random, or a rotating mask; one long hold
  initial begin : receiver
    int         mode;
    int         span;
    logic [7:0] mask;
    bit         hold_done;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 80);
      mask = 8'($urandom);
      repeat (span) begin
        if (!hold_done && results_seen >= HOLD_AFTER) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 99) < 70);
          default: begin
            m_tready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    bbo_pkg::item_t directed [$];
    int             p;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;

    // slot pool: all-zero and all-max corners, the rest random valid
    for (p = 0; p < 8; p++) begin
      pool_cat[p]  = 8'($urandom_range(0, bbo_pkg::BLOCK_CATEGORIES - 1));
      pool_sub[p]  = 8'($urandom_range(0, bbo_pkg::SUBBLK_COUNT - 1));
      pool_pos[p]  = 8'($urandom_range(0, bbo_pkg::COEFF_POSITIONS - 1));
      pool_part[p] = 8'($urandom_range(0, bbo_pkg::PARTITIONS - 1));
      pool_comp[p] = 8'($urandom_range(0, bbo_pkg::VECTOR_COMPONENTS - 1));
    end
    pool_cat[0] = 8'd0;  pool_sub[0] = 8'd0;  pool_pos[0] = 8'd0;
    pool_part[0] = 8'd0; pool_comp[0] = 8'd0;
    pool_cat[1]  = 8'(bbo_pkg::BLOCK_CATEGORIES - 1);
    pool_sub[1]  = 8'(bbo_pkg::SUBBLK_COUNT - 1);
    pool_pos[1]  = 8'(bbo_pkg::COEFF_POSITIONS - 1);
    pool_part[1] = 8'(bbo_pkg::PARTITIONS - 1);
    pool_comp[1] = 8'(bbo_pkg::VECTOR_COMPONENTS - 1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty after reset, set and read back in every domain, corner indices
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(make_item(bbo_pkg::OP_SET, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 1, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_LSB,
                                 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(bbo_pkg::OP_SET, bbo_pkg::DOM_COEFF_LSB,
                                 4, 15, 15, 255, 255, 0, 1));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_LSB,
                                 4, 15, 15, 255, 255, 0, 1));
    // mvd domains ignore the coefficient indices
    directed.push_back(make_item(bbo_pkg::OP_SET, bbo_pkg::DOM_MVD_SIGN,
                                 255, 255, 255, 15, 1, 1, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_MVD_SIGN,
                                 255, 255, 255, 15, 1, 0, 0));
    directed.push_back(make_item(bbo_pkg::OP_SET, bbo_pkg::DOM_MVD_LSB,
                                 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_MVD_LSB,
                                 0, 0, 0, 0, 0, 0, 1));
    // override values that cannot be stored leave the slot alone
    directed.push_back(make_item(bbo_pkg::OP_SET, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 2, 0));
    directed.push_back(make_item(bbo_pkg::OP_SET, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 3, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 0, 0));
    // out-of-range indices: set ignored, apply passes through
    directed.push_back(make_item(bbo_pkg::OP_SET, bbo_pkg::DOM_COEFF_SIGN,
                                 5, 0, 0, 0, 0, 1, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_SIGN,
                                 5, 0, 0, 0, 0, 0, 1));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_LSB,
                                 0, 16, 16, 0, 0, 0, 1));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_SIGN,
                                 255, 255, 255, 0, 0, 3, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_MVD_SIGN,
                                 0, 0, 0, 16, 0, 0, 1));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_MVD_LSB,
                                 0, 0, 0, 0, 2, 0, 1));
    // invalid domains
    directed.push_back(make_item(bbo_pkg::OP_SET, DOM_BAD_LO, 0, 0, 0, 0, 0, 1, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, DOM_BAD_HI, 0, 0, 0, 0, 0, 0, 1));
    // no-op opcode, then clear with junk fields and check the table is empty
    directed.push_back(make_item(bbo_pkg::OP_NOP, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 1, 1));
    directed.push_back(make_item(bbo_pkg::OP_CLEAR, DOM_BAD_HI,
                                 255, 255, 255, 255, 255, 3, 1));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_COEFF_SIGN,
                                 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(bbo_pkg::OP_APPLY, bbo_pkg::DOM_MVD_SIGN,
                                 0, 0, 0, 15, 1, 0, 1));
    foreach (directed[i]) send_item(directed[i]);

    // set/apply traffic with occasional clears
    repeat (580) send_item(random_item(3));
    // clear-heavy stretch: carries the generation tag past its wrap
    repeat (320) send_item(random_item(85));

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("bypass_bin_override_table verification clean");
    end else begin
      $display("bypass_bin_override_table verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bbo_pkg.sv
sv/bbo_ctrl.sv
sv/bbo_datapath.sv
sv/bypass_bin_override_table.sv
sv/bbo_checker.sv
test/tb.sv
